FILE: sv/ppfp_pkg.sv
// ============================================================================
// ppfp_pkg: shared types and constants of the ping-pong frame player
// Holds the input and result word structs, the list sizes and the action and
// status codes.
// ============================================================================
package ppfp_pkg;

    localparam int LIST_FRAMES = 256;
    localparam int LIST_WORDS  = 4096;
    localparam int FRAME_WORDS = 64;

    typedef enum logic [2:0] {
        ACT_TICK  = 3'd0,
        ACT_RESET = 3'd1,
        ACT_ABORT = 3'd2,
        ACT_BEGIN = 3'd3,
        ACT_PUSH  = 3'd4,
        ACT_END   = 3'd5,
        ACT_CLEAR = 3'd6,
        ACT_NONE  = 3'd7
    } t_action;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_REJ  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [3:0] GAIN_CODE   = 4'h2;
    localparam logic [3:0] COMMIT_CODE = 4'hF;
    localparam int         ZERO_WORDS  = 16;

    typedef struct packed {
        logic [2:0]  action;
        logic        list_select;
        logic [8:0]  frame_total;
        logic [31:0] push_word;
        logic        last_word;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] out_word;
        logic        end_of_run;
        logic [1:0]  status;
        logic        is_playing;
        logic        active_list;
        logic [8:0]  frame_position;
        logic [8:0]  free_frames_a;
        logic [8:0]  free_frames_b;
        logic [31:0] switch_count;
        logic [31:0] hold_count;
    } t_out_item;

    // Job handed from the control front to the word emitter.
    typedef struct packed {
        logic        words;      // 1: stream words, 0: one status item
        logic        abort;      // generate the abort sequence
        logic        list;       // list to read for a frame
        logic [11:0] start;      // first word address within the list
        logic [6:0]  count;      // number of frame words
        t_out_item   snap;       // state snapshot and status
    } t_job;

endpackage

FILE: sv/ppfp_ram.sv
// ============================================================================
// ppfp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
module ppfp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: sv/ppfp_front.sv
// ============================================================================
// ppfp_front: command decoder and list bookkeeping
// Applies each action to the list state, writes pushed words and frame
// descriptors, and queues one job per action for the word emitter.
// ============================================================================
module ppfp_front import ppfp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_go,
    input  t_in_item i_item,
    // frame descriptor read, data arrives in the next cycle
    output logic [8:0]  o_desc_raddr,
    input  logic [18:0] i_desc_rdata,
    output logic        o_desc_we,
    output logic [8:0]  o_desc_waddr,
    output logic [18:0] o_desc_wdata,
    output logic        o_word_we,
    output logic [12:0] o_word_waddr,
    output logic [31:0] o_word_wdata,
    output logic        o_busy,
    output logic        o_job_valid,
    output t_job        o_job,
    input  logic        i_job_full
);
    typedef enum logic [1:0] {S_IDLE, S_DESC, S_WAIT} t_state;

    t_state      r_state;
    logic [8:0]  r_exp    [2];
    logic [8:0]  r_loaded [2];
    logic [12:0] r_used   [2];
    logic        r_ready  [2];
    logic [6:0]  r_open;
    logic        r_play;
    logic        r_cur;
    logic [8:0]  r_frame;
    logic [31:0] r_sw;
    logic [31:0] r_hold;
    logic        r_job_valid;
    t_job        r_job;

    logic [8:0]  n_exp    [2];
    logic [8:0]  n_loaded [2];
    logic [12:0] n_used   [2];
    logic        n_ready  [2];
    logic [6:0]  n_open;
    logic        n_play;
    logic        n_cur;
    logic [8:0]  n_frame;
    logic [31:0] n_sw;
    logic [31:0] n_hold;
    logic [1:0]  n_status;
    logic        n_emit;      // the action emits a status job (or, for abort, the abort job)
    logic        n_abort;
    logic        n_tick_frame;
    logic        n_desc;
    logic        l;
    logic [13:0] fill;

    function automatic logic [8:0] free_of(input logic [8:0] e, input logic [8:0] ld);
        return (e > ld) ? e - ld : 9'd0;
    endfunction

    // Actions are applied in S_IDLE; a tick that plays a frame first fetches
    // its descriptor and finishes in S_DESC.
    always_comb begin
        n_exp = r_exp; n_loaded = r_loaded; n_used = r_used; n_ready = r_ready;
        n_open = r_open; n_play = r_play; n_cur = r_cur; n_frame = r_frame;
        n_sw = r_sw; n_hold = r_hold; n_status = ST_OK;
        n_emit = 1'b0; n_abort = 1'b0; n_tick_frame = 1'b0; n_desc = 1'b0;
        o_word_we = 1'b0; o_desc_we = 1'b0;
        l = i_item.list_select;
        fill = 14'(r_used[l]) + 14'(r_open) + 14'd1;
        o_word_waddr = {l, 12'(r_used[l] + 13'(r_open))};
        o_word_wdata = i_item.push_word;
        o_desc_waddr = {l, 8'(r_loaded[l])};
        o_desc_wdata = {12'(r_used[l]), 7'(r_open + 7'd1)};
        o_desc_raddr = {r_cur, 8'(r_frame)};

        if (r_state == S_IDLE && i_go) begin
            n_emit = 1'b1;
            unique case (t_action'(i_item.action))
                ACT_TICK: begin
                    if (!r_play) begin
                        n_emit = 1'b1;
                    end else if (r_frame < r_loaded[r_cur]) begin
                        n_emit = 1'b0; n_desc = 1'b1;
                    end else begin
                        if (r_ready[!r_cur] && r_loaded[!r_cur] != 9'd0) begin
                            n_exp[r_cur] = '0; n_loaded[r_cur] = '0;
                            n_used[r_cur] = '0; n_ready[r_cur] = 1'b0;
                            n_cur = !r_cur; n_frame = '0; n_sw = r_sw + 32'd1;
                        end else begin
                            n_hold = r_hold + 32'd1;
                        end
                    end
                end
                ACT_RESET, ACT_ABORT: begin
                    n_play = 1'b0; n_cur = 1'b0; n_frame = '0; n_open = '0;
                    for (int k = 0; k < 2; k++) begin
                        n_exp[k] = '0; n_loaded[k] = '0; n_used[k] = '0; n_ready[k] = 1'b0;
                    end
                    n_abort = (i_item.action == ACT_ABORT);
                end
                ACT_BEGIN: begin
                    if (i_item.frame_total == 9'd0 || 32'(i_item.frame_total) > LIST_FRAMES) begin
                        n_status = ST_REJ;
                    end else begin
                        n_exp[l] = i_item.frame_total; n_loaded[l] = '0;
                        n_used[l] = '0; n_ready[l] = 1'b0; n_open = '0;
                    end
                end
                ACT_PUSH: begin
                    if (r_loaded[l] >= r_exp[l] || 32'(r_loaded[l]) >= LIST_FRAMES) begin
                        n_status = ST_REJ; n_open = '0;
                    end else if (32'(r_open) >= FRAME_WORDS) begin
                        n_status = ST_REJ; n_open = '0;
                    end else if (32'(fill) > LIST_WORDS) begin
                        n_status = ST_FULL; n_open = '0;
                    end else begin
                        o_word_we = 1'b1;
                        n_open = r_open + 7'd1;
                        if (i_item.last_word) begin
                            o_desc_we = 1'b1;
                            n_used[l] = r_used[l] + 13'(r_open) + 13'd1;
                            n_loaded[l] = r_loaded[l] + 9'd1;
                            n_open = '0;
                            if (n_loaded[l] == r_exp[l]) begin
                                n_ready[l] = 1'b1;
                                if (!r_play && l == 1'b0) begin
                                    n_cur = 1'b0; n_frame = '0; n_play = 1'b1;
                                end
                            end
                        end
                    end
                end
                ACT_END: begin
                    if (r_loaded[l] == 9'd0) begin
                        n_status = ST_REJ;
                    end else begin
                        n_ready[l] = 1'b1;
                        if (!r_play && l == 1'b0) begin
                            n_cur = 1'b0; n_frame = '0; n_play = 1'b1;
                        end
                    end
                end
                ACT_CLEAR: begin
                    n_exp[l] = '0; n_loaded[l] = '0; n_used[l] = '0;
                    n_ready[l] = 1'b0; n_open = '0;
                end
                default: n_status = ST_REJ;
            endcase
        end else if (r_state == S_DESC) begin
            // Descriptor is on the read port; advance and maybe finish the list.
            n_tick_frame = 1'b1;
            n_frame = r_frame + 9'd1;
            if (n_frame >= r_loaded[r_cur]) begin
                n_exp[r_cur] = '0; n_loaded[r_cur] = '0;
                n_used[r_cur] = '0; n_ready[r_cur] = 1'b0;
                n_frame = '0;
                if (r_ready[!r_cur] && r_loaded[!r_cur] != 9'd0) begin
                    n_cur = !r_cur; n_sw = r_sw + 32'd1;
                end else begin
                    n_play = 1'b0; n_hold = r_hold + 32'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int k = 0; k < 2; k++) begin
                r_exp[k] <= '0; r_loaded[k] <= '0; r_used[k] <= '0; r_ready[k] <= 1'b0;
            end
            r_open <= '0; r_play <= 1'b0; r_cur <= 1'b0; r_frame <= '0;
            r_sw <= '0; r_hold <= '0; r_job_valid <= 1'b0;
        end else begin
            r_exp <= n_exp; r_loaded <= n_loaded; r_used <= n_used; r_ready <= n_ready;
            r_open <= n_open; r_play <= n_play; r_cur <= n_cur; r_frame <= n_frame;
            r_sw <= n_sw; r_hold <= n_hold;
            r_job_valid <= n_emit || n_tick_frame;
            unique case (r_state)
                S_IDLE:  r_state <= n_desc ? S_DESC : (n_emit ? S_WAIT : S_IDLE);
                S_DESC:  r_state <= S_WAIT;
                S_WAIT:  r_state <= i_job_full ? S_WAIT : S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
        if (n_emit || n_tick_frame) begin
            r_job.words  <= n_tick_frame || n_abort;
            r_job.abort  <= n_abort;
            r_job.list   <= r_cur;
            r_job.start  <= i_desc_rdata[18:7];
            r_job.count  <= i_desc_rdata[6:0];
            r_job.snap.result_kind    <= n_tick_frame || n_abort;
            r_job.snap.out_word       <= '0;
            r_job.snap.end_of_run     <= 1'b1;
            r_job.snap.status         <= n_status;
            r_job.snap.is_playing     <= n_play;
            r_job.snap.active_list    <= n_cur;
            r_job.snap.frame_position <= n_frame;
            r_job.snap.free_frames_a  <= free_of(n_exp[0], n_loaded[0]);
            r_job.snap.free_frames_b  <= free_of(n_exp[1], n_loaded[1]);
            r_job.snap.switch_count   <= n_sw;
            r_job.snap.hold_count     <= n_hold;
        end
    end

    // The front holds its next command until the queue has room.
    assign o_busy      = (r_state != S_IDLE) || i_job_full;
    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;
endmodule

FILE: sv/ppfp_back.sv
// ============================================================================
// ppfp_back: job queue and word emitter
// Buffers jobs from the front and streams frame words, abort words or a
// status item, one result per cycle.
// ============================================================================
module ppfp_back import ppfp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    input  t_job        i_job,
    output logic        o_full,
    output logic        o_idle,
    output logic [12:0] o_word_raddr,
    input  logic [31:0] i_word_rdata,
    output logic        o_valid,
    output t_out_item   o_item
);
    typedef enum logic [1:0] {B_IDLE, B_RUN} t_bstate;

    t_job        r_q [2];
    logic [1:0]  r_cnt;
    logic        r_wp, r_rp;
    t_bstate     r_state;
    t_job        r_cur;
    logic [6:0]  r_idx;       // next word index to read
    logic [6:0]  r_total;
    logic        r_rd_v;      // a read is in flight
    logic        r_rd_last;
    logic        r_valid;
    t_out_item   r_item;
    logic        pop, rd_fire, push;

    assign push = i_job_valid;
    assign pop  = (r_state == B_IDLE) && (r_cnt != 2'd0);
    assign rd_fire = (r_state == B_RUN) && (r_idx != r_total);
    assign o_word_raddr = {r_cur.list, 12'(r_cur.start + 12'(r_idx))};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0; r_wp <= 1'b0; r_rp <= 1'b0; r_state <= B_IDLE;
            r_rd_v <= 1'b0; r_valid <= 1'b0; r_idx <= '0; r_total <= '0;
        end else begin
            if (push) begin
                r_q[r_wp] <= i_job; r_wp <= !r_wp;
            end
            if (pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
            r_valid <= 1'b0;
            r_rd_v  <= 1'b0;
            unique case (r_state)
                B_IDLE: begin
                    if (pop) begin
                        r_cur <= r_q[r_rp];
                        r_idx <= '0;
                        if (!r_q[r_rp].words) begin
                            r_valid <= 1'b1; r_item <= r_q[r_rp].snap;
                        end else begin
                            r_state <= B_RUN;
                            r_total <= r_q[r_rp].abort ? 7'(ZERO_WORDS + 1)
                                                       : r_q[r_rp].count;
                        end
                    end
                end
                B_RUN: begin
                    if (rd_fire) begin
                        r_idx <= r_idx + 7'd1;
                        if (r_cur.abort) begin
                            r_valid <= 1'b1;
                            r_item <= r_cur.snap;
                            r_item.end_of_run <= (r_idx + 7'd1 == r_total);
                            r_item.out_word <= (r_idx == 7'(ZERO_WORDS)) ?
                                {COMMIT_CODE, 28'd0} :
                                {GAIN_CODE, r_idx[3], r_idx[2:0], 24'd0};
                            if (r_idx + 7'd1 == r_total) r_state <= B_IDLE;
                        end else begin
                            r_rd_v <= 1'b1;
                            r_rd_last <= (r_idx + 7'd1 == r_total);
                        end
                    end
                    if (r_rd_v) begin
                        r_valid <= 1'b1;
                        r_item <= r_cur.snap;
                        r_item.out_word <= i_word_rdata;
                        r_item.end_of_run <= r_rd_last;
                        if (r_rd_last) r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_full  = (r_cnt == 2'd2) || (r_cnt == 2'd1 && push);
    assign o_idle  = (r_state == B_IDLE) && (r_cnt == 2'd0);
    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

FILE: sv/ping_pong_frame_player_core.sv
// ============================================================================
// ping_pong_frame_player_core: two-list ping-pong frame player
// A command other than a playing tick or an abort gives one status word; the
// next command is taken once the front and the emitter are idle again. A
// tick that plays an n-word frame reads its descriptor, strobes its n words
// and then frees the input. Abort strobes 17 words. The receiver cannot stall.
// Synchronous active-low reset clears all control state, not the stores.
// ============================================================================
module ping_pong_frame_player_core import ppfp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_strobe,
    output t_out_item o_item
);
    logic        desc_we, word_we, job_valid, job_full, back_idle, f_busy;
    logic [8:0]  desc_raddr, desc_waddr;
    logic [18:0] desc_rdata, desc_wdata;
    logic [12:0] word_waddr, word_raddr;
    logic [31:0] word_wdata, word_rdata;
    t_job        job;

    ppfp_front u_front (
        .i_clk, .i_rst_n, .i_go(start && !busy), .i_item,
        .o_desc_raddr(desc_raddr), .i_desc_rdata(desc_rdata),
        .o_desc_we(desc_we), .o_desc_waddr(desc_waddr), .o_desc_wdata(desc_wdata),
        .o_word_we(word_we), .o_word_waddr(word_waddr), .o_word_wdata(word_wdata),
        .o_busy(f_busy), .o_job_valid(job_valid), .o_job(job), .i_job_full(job_full)
    );

    ppfp_ram #(.WIDTH(19), .DEPTH(2 * LIST_FRAMES)) u_desc (
        .i_clk, .i_we(desc_we), .i_waddr(desc_waddr), .i_wdata(desc_wdata),
        .i_raddr(desc_raddr), .o_rdata(desc_rdata)
    );

    ppfp_ram #(.WIDTH(32), .DEPTH(2 * LIST_WORDS)) u_words (
        .i_clk, .i_we(word_we), .i_waddr(word_waddr), .i_wdata(word_wdata),
        .i_raddr(word_raddr), .o_rdata(word_rdata)
    );

    ppfp_back u_back (
        .i_clk, .i_rst_n, .i_job_valid(job_valid), .i_job(job), .o_full(job_full),
        .o_idle(back_idle), .o_word_raddr(word_raddr), .i_word_rdata(word_rdata),
        .o_valid(o_strobe), .o_item
    );

    // Items are serialized: one in flight from front through emitter.
    assign busy = f_busy || !back_idle || job_valid;
endmodule

FILE: sv/ppfp_checker.sv
// ============================================================================
// ppfp_sva: port-level checks for the frame player
// Watches the command and result ports of the top level.
// ============================================================================
module ppfp_sva import ppfp_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input logic      o_strobe,
    input t_out_item o_item
);
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("busy did not rise after a command");
    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_item.result_kind |-> o_item.end_of_run)
        else $error("status item not last");
    a_status_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_item.result_kind |-> o_item.out_word == 32'd0)
        else $error("status item carries a word");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_item.status != 2'd3) else $error("bad status code");
endmodule

bind ping_pong_frame_player_core ppfp_sva u_sva (
    .i_clk, .i_rst_n, .start, .busy, .o_strobe, .o_item
);
